// ===== rtl/sha1_message_digest_top_assert.svh =====
// Assertion macros for the SHA-1 digest block.
`ifndef SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_TOP_ASSERT_SVH
`ifndef SYNTH
`define SHA1MD_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sha1md: same-cycle check failed");
`define SHA1MD_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sha1md: next-cycle check failed");
`else
`define SHA1MD_ASSERT_NOW(label, ck, rn, ante, cons)
`define SHA1MD_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

// ===== rtl/sha1md_pkg.sv =====
package sha1md_pkg;

    typedef logic [31:0] word_t;
    // Element 0 is word a / H0, element 4 is word e / H4.
    typedef logic [4:0][31:0] hash_t;

    localparam hash_t INIT_HASH = {
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam word_t K_ROUND0 = 32'h5A827999;
    localparam word_t K_ROUND1 = 32'h6ED9EBA1;
    localparam word_t K_ROUND2 = 32'h8F1BBCDC;
    localparam word_t K_ROUND3 = 32'hCA62C1D6;

    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [7:0] PAD_MARK = 8'h80;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [7:0] data;
    } sched_ctl_t;

    typedef struct packed {
        logic       init;
        logic       step;
        logic [6:0] rnd;
    } round_ctl_t;

    // Round function plus round constant for round rnd.
    function automatic word_t round_fk(input logic [6:0] rnd, input word_t b,
                                       input word_t c, input word_t d);
        word_t res;
        priority if (rnd < 7'd20) begin
            res = ((b & c) | (~b & d)) + K_ROUND0;
        end
        else if (rnd < 7'd40) begin
            res = (b ^ c ^ d) + K_ROUND1;
        end
        else if (rnd < 7'd60) begin
            res = ((b & c) | (b & d) | (c & d)) + K_ROUND2;
        end
        else begin
            res = (b ^ c ^ d) + K_ROUND3;
        end
        return res;
    endfunction

endpackage

// ===== rtl/sha1_message_digest_top.sv =====
// SHA-1 message digest, one message byte per input transfer.
// Input channel s_axis: tdata carries the byte, tuser[0] says whether tdata
// holds a byte (a bare transfer with tuser low carries none), and tlast ends
// the message. An empty message is a single bare transfer with tlast high.
// Output channel m_axis: one 160-bit digest per message, word 0 in the low bits.
// When the 64th byte of a block arrives, the block goes through 80 rounds of the
// shared round unit and then the chaining add, during which s_axis_tready is low.
// After tlast the padding is written one byte per cycle, up to the end of the
// block and through one more block if the length spills into it; each padded
// block goes through the rounds and the chaining add, and the digest then loads
// the output register. The round unit and the single-byte write path into the
// block limit the throughput.
// The output register holds the digest while m_axis_tready is low; the next
// message is taken meanwhile, and only its own digest waits for the register.
// Reset clears the chaining value to the SHA-1 initial hash, the byte count and
// the output valid; any partial message is dropped.
`include "sha1_message_digest_top_assert.svh"

module sha1_message_digest_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic [0:0]   s_axis_tuser,   // [0] has_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata    // digest_word0 .. digest_word4, 32 bits each
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PAD   = 5'b00010,
        ST_ROUND = 5'b00100,
        ST_ADD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [5:0]             fill_reg;
    logic [5:0]             fill_next;
    logic [60:0]            byte_cnt_reg;
    logic [60:0]            byte_cnt_next;
    logic [60:0]            byte_cnt_inc;
    logic [63:0]            len_reg;
    logic [63:0]            len_next;
    logic [6:0]             rnd_reg;
    logic [6:0]             rnd_next;
    sha1md_pkg::hash_t      chain_reg;
    sha1md_pkg::hash_t      chain_next;
    logic                   last_reg;
    logic                   last_next;
    logic                   sent80_reg;
    logic                   sent80_next;
    logic                   len_ok_reg;
    logic                   len_ok_next;
    logic                   final_reg;
    logic                   final_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    sha1md_pkg::hash_t      out_data_reg;
    sha1md_pkg::hash_t      out_data_next;

    logic                   s_fire;
    logic                   len_field;
    logic [7:0]             pad_byte;
    sha1md_pkg::sched_ctl_t sched_ctl;
    sha1md_pkg::round_ctl_t round_ctl;
    sha1md_pkg::word_t      w_cur;
    sha1md_pkg::hash_t      round_vars;

    sha1md_sched u_sched (
        .clk   (clk),
        .ctl   (sched_ctl),
        .w_cur (w_cur)
    );

    sha1md_round u_round (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (round_ctl),
        .w     (w_cur),
        .chain (chain_reg),
        .vars  (round_vars)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign byte_cnt_inc  = byte_cnt_reg + 61'd1;

    // Length bytes go in the last eight positions of a block, once the 0x80
    // marker has been written and has left room for them.
    assign len_field = sent80_reg & len_ok_reg & (fill_reg[5:3] == 3'b111);
    assign pad_byte  = !sent80_reg ? sha1md_pkg::PAD_MARK :
                       len_field   ? len_reg[63:56] : 8'h00;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        byte_cnt_next  = byte_cnt_reg;
        len_next       = len_reg;
        rnd_next       = rnd_reg;
        chain_next     = chain_reg;
        last_next      = last_reg;
        sent80_next    = sent80_reg;
        len_ok_next    = len_ok_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg & ~m_axis_tready;
        out_data_next  = out_data_reg;
        sched_ctl      = '{load: 1'b0, step: 1'b0, data: s_axis_tdata};
        round_ctl      = '{init: 1'b0, step: 1'b0, rnd: rnd_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_axis_tuser[0]) begin
                        sched_ctl.load = 1'b1;
                        fill_next      = fill_reg + 6'd1;
                        byte_cnt_next  = byte_cnt_inc;
                    end
                    if (s_axis_tlast) begin
                        last_next   = 1'b1;
                        sent80_next = 1'b0;
                        len_ok_next = 1'b0;
                        final_next  = 1'b0;
                        len_next    = {byte_cnt_next, 3'b000};
                    end
                    if (s_axis_tuser[0] && (fill_reg == 6'd63)) begin
                        state_next     = ST_ROUND;
                        rnd_next       = 7'd0;
                        round_ctl.init = 1'b1;
                    end
                    else if (s_axis_tlast) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                sched_ctl.load = 1'b1;
                sched_ctl.data = pad_byte;
                fill_next      = fill_reg + 6'd1;
                sent80_next    = 1'b1;
                len_ok_next    = len_ok_reg | (!sent80_reg && (fill_reg[5:3] != 3'b111))
                                 | (fill_reg == 6'd63);
                if (len_field) begin
                    len_next = {len_reg[55:0], 8'h00};
                end
                if (len_field && (fill_reg == 6'd63)) begin
                    final_next = 1'b1;
                end
                if (fill_reg == 6'd63) begin
                    state_next     = ST_ROUND;
                    rnd_next       = 7'd0;
                    round_ctl.init = 1'b1;
                end
            end
            ST_ROUND: begin
                sched_ctl.step = 1'b1;
                round_ctl.step = 1'b1;
                rnd_next       = rnd_reg + 7'd1;
                if (rnd_reg == sha1md_pkg::LAST_ROUND) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 5; i++) begin
                    chain_next[i] = chain_reg[i] + round_vars[i];
                end
                priority if (final_reg) begin
                    state_next = ST_EMIT;
                end
                else if (last_reg) begin
                    state_next = ST_PAD;
                end
                else begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next = 1'b1;
                    out_data_next  = chain_reg;
                    chain_next     = sha1md_pkg::INIT_HASH;
                    byte_cnt_next  = '0;
                    last_next      = 1'b0;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            byte_cnt_reg  <= '0;
            rnd_reg       <= '0;
            chain_reg     <= sha1md_pkg::INIT_HASH;
            last_reg      <= 1'b0;
            sent80_reg    <= 1'b0;
            len_ok_reg    <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            byte_cnt_reg  <= byte_cnt_next;
            rnd_reg       <= rnd_next;
            chain_reg     <= chain_next;
            last_reg      <= last_next;
            sent80_reg    <= sent80_next;
            len_ok_reg    <= len_ok_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg      <= len_next;
        out_data_reg <= out_data_next;
    end

    `SHA1MD_ASSERT_NEXT(a_full_block_runs, clk, rst_n, s_fire && s_axis_tuser[0] && (fill_reg == 6'd63), state_reg == ST_ROUND)
    `SHA1MD_ASSERT_NOW(a_round_range, clk, rst_n, state_reg == ST_ROUND, rnd_reg <= sha1md_pkg::LAST_ROUND)
    `SHA1MD_ASSERT_NOW(a_emit_after_length, clk, rst_n, state_reg == ST_EMIT, final_reg && last_reg && len_ok_reg)
    `SHA1MD_ASSERT_NOW(a_out_from_emit, clk, rst_n, $rose(m_axis_tvalid), $past(state_reg == ST_EMIT))

endmodule

// ===== rtl/sha1md_sched.sv =====
module sha1md_sched (
    input  logic                   clk,
    input  sha1md_pkg::sched_ctl_t ctl,
    output sha1md_pkg::word_t      w_cur
);

    // The 64-byte block as a shift line: bytes enter at the bottom while
    // filling, and the message schedule shifts a word per round.
    logic [511:0]      blk_reg;
    logic [511:0]      blk_next;
    sha1md_pkg::word_t mix;
    sha1md_pkg::word_t w_new;

    assign w_cur = blk_reg[511:480];
    assign mix   = blk_reg[511:480] ^ blk_reg[447:416] ^ blk_reg[255:224] ^ blk_reg[95:64];
    assign w_new = {mix[30:0], mix[31]};

    always_comb
    begin
        blk_next = blk_reg;
        priority if (ctl.load) begin
            blk_next = {blk_reg[503:0], ctl.data};
        end
        else if (ctl.step) begin
            blk_next = {blk_reg[479:0], w_new};
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
    end

endmodule

// ===== rtl/sha1md_round.sv =====
module sha1md_round (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sha1md_pkg::round_ctl_t ctl,
    input  sha1md_pkg::word_t      w,
    input  sha1md_pkg::hash_t      chain,
    output sha1md_pkg::hash_t      vars
);

    sha1md_pkg::hash_t vars_reg;
    sha1md_pkg::hash_t vars_next;
    sha1md_pkg::word_t a;
    sha1md_pkg::word_t b;
    sha1md_pkg::word_t tmp;

    assign a    = vars_reg[0];
    assign b    = vars_reg[1];
    assign tmp  = {a[26:0], a[31:27]} + sha1md_pkg::round_fk(ctl.rnd, b, vars_reg[2], vars_reg[3])
                  + vars_reg[4] + w;
    assign vars = vars_reg;

    always_comb
    begin
        vars_next = vars_reg;
        priority if (ctl.init) begin
            vars_next = chain;
        end
        else if (ctl.step) begin
            vars_next[0] = tmp;
            vars_next[1] = a;
            vars_next[2] = {b[1:0], b[31:2]};
            vars_next[3] = vars_reg[2];
            vars_next[4] = vars_reg[3];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vars_reg <= '0;
        end
        else begin
            vars_reg <= vars_next;
        end
    end

endmodule

// ===== verif/sha1_message_digest_top_tb.sv =====
module sha1_message_digest_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD   = 2000;
    localparam int DRAIN_WAIT  = 400;

    // Keeps its own SHA-1 state and a queue of the digests still owed by the block.
    class sha1_scoreboard;
        sha1md_pkg::word_t chain[5];
        sha1md_pkg::word_t blk[16];
        logic [60:0]       nbytes;
        logic [159:0]      digest_q[$];
        int                errors;

        function new();
            for (int i = 0; i < 16; i++) blk[i] = '0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 5; i++) chain[i] = sha1md_pkg::INIT_HASH[i];
            nbytes = '0;
        endfunction

        function sha1md_pkg::word_t rotl(sha1md_pkg::word_t v, int n);
            return (v << n) | (v >> (32 - n));
        endfunction

        function void compress();
            sha1md_pkg::word_t w[80];
            sha1md_pkg::word_t a, b, c, d, e, f, k, tmp;
            for (int t = 0; t < 16; t++) w[t] = blk[t];
            for (int t = 16; t < 80; t++)
                w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
            a = chain[0];
            b = chain[1];
            c = chain[2];
            d = chain[3];
            e = chain[4];
            for (int t = 0; t < 80; t++) begin
                if (t < 20) begin
                    f = (b & c) | (~b & d);
                    k = 32'h5A827999;
                end
                else if (t < 40) begin
                    f = b ^ c ^ d;
                    k = 32'h6ED9EBA1;
                end
                else if (t < 60) begin
                    f = (b & c) | (b & d) | (c & d);
                    k = 32'h8F1BBCDC;
                end
                else begin
                    f = b ^ c ^ d;
                    k = 32'hCA62C1D6;
                end
                tmp = rotl(a, 5) + f + e + w[t] + k;
                e = d;
                d = c;
                c = rotl(b, 30);
                b = a;
                a = tmp;
            end
            chain[0] += a;
            chain[1] += b;
            chain[2] += c;
            chain[3] += d;
            chain[4] += e;
        endfunction

        // Bytes go in big-endian, so byte 0 of a word lands in its top bits.
        function void place(int pos, logic [7:0] v);
            int idx;
            int sh;
            idx = pos >> 2;
            sh = (3 - (pos & 3)) * 8;
            if ((pos & 3) == 0)
                blk[idx] = sha1md_pkg::word_t'(v) << sh;
            else
                blk[idx] |= sha1md_pkg::word_t'(v) << sh;
        endfunction

        function void note_input(logic [7:0] d, logic has, logic lst);
            int           pos;
            logic [63:0]  bitlen;
            logic [159:0] dg;
            if (has) begin
                pos = int'(nbytes[5:0]);
                place(pos, d);
                nbytes = nbytes + 61'd1;
                if (pos == 63)
                    compress();
            end
            if (!lst)
                return;
            pos = int'(nbytes[5:0]);
            place(pos, sha1md_pkg::PAD_MARK);
            for (int i = (pos >> 2) + 1; i < 16; i++) blk[i] = '0;
            // No room left for the length, so it goes into one more block.
            if (pos >= 56) begin
                compress();
                for (int i = 0; i < 14; i++) blk[i] = '0;
            end
            bitlen = {nbytes, 3'b000};
            blk[14] = bitlen[63:32];
            blk[15] = bitlen[31:0];
            compress();
            for (int i = 0; i < 5; i++) dg[32*i +: 32] = chain[i];
            digest_q.push_back(dg);
            restart();
        endfunction

        function void check_digest(logic [159:0] act);
            logic [159:0] exp_dg;
            if (digest_q.size() == 0) begin
                $display("%0t: digest with none pending, actual %h", $time, act);
                errors++;
                return;
            end
            exp_dg = digest_q.pop_front();
            for (int i = 0; i < 5; i++) begin
                if (act[32*i +: 32] !== exp_dg[32*i +: 32]) begin
                    $display("%0t: digest_word%0d expected %h actual %h", $time, i,
                             exp_dg[32*i +: 32], act[32*i +: 32]);
                    errors++;
                end
            end
        endfunction

        function int outstanding();
            return digest_q.size();
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;   // [7:0] data_byte
    logic [0:0]   s_axis_tuser;   // [0] has_byte
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [159:0] m_axis_tdata;   // digest_word0 .. digest_word4, 32 bits each

    sha1_scoreboard sb;
    bit  idle_on;
    bit  tx_bursty;
    bit  rx_hold_req;
    int  items_sent;
    int  quiet_cycles;

    sha1_message_digest_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_digest(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Digest side: random back-pressure, plus one long hold on request.
    initial begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic [7:0] d, input logic has, input logic lst);
        int gap;
        if (idle_on && tx_bursty && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom);
            s_axis_tuser  <= 1'($urandom);
            s_axis_tlast  <= 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= has;
        s_axis_tlast  <= lst;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        if (has || lst)
            items_sent++;
    endtask

    // A message of len bytes; the end comes with the last byte or as a bare transfer.
    task automatic send_message(input int len, input bit bare_end);
        tx_bursty = ($urandom_range(0, 2) != 0);
        for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, (j == len - 1) && !bare_end);
        end
        if (bare_end || len == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 8);
        else if (r < 75)
            return $urandom_range(9, 63);
        else if (r < 95)
            return ($urandom_range(0, 1) == 0) ? $urandom_range(52, 66)
                                               : $urandom_range(116, 130);
        else
            return $urandom_range(64, 200);
    endfunction

    task automatic send_random_until(input int target);
        while (items_sent < target)
            send_message(pick_length(), $urandom_range(0, 3) == 0);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.outstanding() != 0) @(negedge clk);
    endtask

    initial begin
        sb = new();
        idle_on = 1'b1;
        tx_bursty = 1'b1;
        rx_hold_req = 1'b0;
        items_sent = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty message, then a bare non-last transfer followed by a bare end.
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        // Single bytes at both extremes, one ending on the byte, one on a bare end.
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        // The classic "abc" message.
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b1);

        // Lengths right at the padding spill and block boundaries.
        send_message(55, 1'b0);
        send_message(56, 1'b1);
        send_message(64, 1'b0);

        send_random_until(300);

        drain_results();

        // Hold the digest side off so the block backs up into its input.
        rx_hold_req = 1'b1;
        for (int m = 0; m < 8; m++)
            send_message($urandom_range(0, 4), $urandom_range(0, 1) == 0);

        send_random_until(500);
        idle_on = 1'b0;
        send_random_until(600);

        drain_results();
        repeat (DRAIN_WAIT) @(negedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
